@@ hw/rtl/kms_pkg.sv @@
// ----------------------------------------------------------------------------
// kms_pkg: shared types and constants for the keypad matrix scanner
// Payload structs, register map, defaults and the row drive mask helper.
// ----------------------------------------------------------------------------
package kms_pkg;

   // Default matrix geometry
   localparam int NUM_ROWS_DEFAULT = 4;
   localparam int NUM_COLS_DEFAULT = 3;

   // Fixed field widths
   localparam int SAMPLE_W = 3;
   localparam int DRIVE_W  = 4;
   localparam int CODE_W   = 4;
   localparam int TIME_W   = 32;
   localparam int DEB_W    = 16;

   // Configuration port
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam logic [CSR_ADDR_W-3:0] REG_DEBOUNCE_MS = '0;
   localparam logic [DEB_W-1:0] DEBOUNCE_MS_RESET = 16'd50;

   // No key / no event code
   localparam logic [CODE_W-1:0] CODE_NONE = '0;

   typedef struct packed {
      logic [SAMPLE_W-1:0] column_sample;
      logic [TIME_W-1:0]   now_ms;
   } req_type;

   typedef struct packed {
      logic [DRIVE_W-1:0] row_drive;
      logic               scan_done;
      logic [CODE_W-1:0]  key_event;
   } rsp_type;

   // Scan outcome handed to the debouncer
   typedef struct packed {
      logic              done;
      logic [CODE_W-1:0] raw;
   } scan_result_type;

   // Active-low drive mask; rows without a drive bit leave all lines high
   function automatic logic [DRIVE_W-1:0] drive_mask(input logic [2:0] row);
      logic [7:0] onehot;
      onehot = 8'd1 << row;
      return ~onehot[DRIVE_W-1:0];
   endfunction

endpackage

@@ hw/rtl/kms_scan.sv @@
// ----------------------------------------------------------------------------
// kms_scan: row sequencer and press tally
// Walks the rows, counts presses over one scan and forms the raw key code.
// ----------------------------------------------------------------------------
module kms_scan #(
   parameter int NUM_ROWS = kms_pkg::NUM_ROWS_DEFAULT,
   parameter int NUM_COLS = kms_pkg::NUM_COLS_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              step,
   input  logic [kms_pkg::SAMPLE_W-1:0]      column_sample,
   output kms_pkg::scan_result_type          scan_result,
   output logic [kms_pkg::DRIVE_W-1:0]       row_drive
);
   import kms_pkg::*;

   localparam int ROW_W = (NUM_ROWS > 1) ? $clog2(NUM_ROWS) : 1;
   localparam logic [ROW_W-1:0] LAST_ROW = ROW_W'(NUM_ROWS - 1);

   logic [ROW_W-1:0]  row_index_ff, row_index_in;
   logic [1:0]        press_tally_ff, press_tally_in;
   logic [CODE_W-1:0] found_code_ff, found_code_in;

   logic [7:0]        released;
   logic [1:0]        tally;
   logic [CODE_W-1:0] code;
   logic              last_row;

   // Tally presses of the driven row; columns beyond the sample read released
   always_comb begin
      released = {5'b11111, column_sample};
      tally    = press_tally_ff;
      code     = found_code_ff;
      for (int col = 0; col < NUM_COLS; col++) begin
         if (!released[col]) begin
            if (tally == 2'd0) begin
               code = CODE_W'(row_index_ff) * CODE_W'(NUM_COLS) + CODE_W'(col) + CODE_W'(1);
            end
            if (tally < 2'd2) begin
               tally = tally + 2'd1;
            end
         end
      end
   end

   // Advance the row; close the scan at the last row
   always_comb begin
      last_row = (row_index_ff == LAST_ROW);
      scan_result.done = last_row;
      scan_result.raw  = (tally == 2'd1) ? code : CODE_NONE;
      if (last_row) begin
         row_index_in   = '0;
         press_tally_in = '0;
         found_code_in  = CODE_NONE;
      end else begin
         row_index_in   = row_index_ff + ROW_W'(1);
         press_tally_in = tally;
         found_code_in  = code;
      end
      row_drive = drive_mask(3'(row_index_in));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_index_ff   <= '0;
         press_tally_ff <= '0;
         found_code_ff  <= CODE_NONE;
      end else if (step) begin
         row_index_ff   <= row_index_in;
         press_tally_ff <= press_tally_in;
         found_code_ff  <= found_code_in;
      end
   end

endmodule

@@ hw/rtl/kms_debounce.sv @@
// ----------------------------------------------------------------------------
// kms_debounce: raw code debouncer
// Holds the last raw code and its change time; reports newly stable presses.
// ----------------------------------------------------------------------------
module kms_debounce (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          step,
   input  kms_pkg::scan_result_type      scan_result,
   input  logic [kms_pkg::TIME_W-1:0]    now_ms,
   input  logic [kms_pkg::DEB_W-1:0]     debounce_ms,
   output logic [kms_pkg::CODE_W-1:0]    key_event
);
   import kms_pkg::*;

   logic [CODE_W-1:0] previous_raw_ff, previous_raw_in;
   logic [CODE_W-1:0] stable_code_ff, stable_code_in;
   logic [TIME_W-1:0] change_stamp_ff, change_stamp_in;
   logic [TIME_W-1:0] elapsed;

   // Record changes, then promote a code that held long enough
   always_comb begin
      previous_raw_in = previous_raw_ff;
      stable_code_in  = stable_code_ff;
      change_stamp_in = change_stamp_ff;
      key_event       = CODE_NONE;
      elapsed         = now_ms - change_stamp_ff;
      if (scan_result.done) begin
         if (scan_result.raw != previous_raw_ff) begin
            previous_raw_in = scan_result.raw;
            change_stamp_in = now_ms;
         end else if (elapsed >= {{(TIME_W-DEB_W){1'b0}}, debounce_ms}) begin
            if (previous_raw_ff != stable_code_ff) begin
               stable_code_in = previous_raw_ff;
               key_event      = previous_raw_ff;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         previous_raw_ff <= CODE_NONE;
         stable_code_ff  <= CODE_NONE;
         change_stamp_ff <= '0;
      end else if (step) begin
         previous_raw_ff <= previous_raw_in;
         stable_code_ff  <= stable_code_in;
         change_stamp_ff <= change_stamp_in;
      end
   end

endmodule

@@ hw/rtl/keypad_matrix_scan_debounce.sv @@
// A sample passes through the input register, then the result register.
// Throughput: one sample per cycle unless rsp_ready stalls; the result register frees as the result is taken.
// Each sample is examined in one pass between the input and result registers.
// Reset: synchronous; clears the scan to the first row, the debounce state,
// and sets debounce_ms to 50. No memory to clear.
// ----------------------------------------------------------------------------
// keypad_matrix_scan_debounce: keypad matrix scanner with debounce
// Takes one row sample per transfer, drives the next row and reports keys.
// ----------------------------------------------------------------------------
module keypad_matrix_scan_debounce #(
   parameter int NUM_ROWS = kms_pkg::NUM_ROWS_DEFAULT,
   parameter int NUM_COLS = kms_pkg::NUM_COLS_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  kms_pkg::req_type                  req_data,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output kms_pkg::rsp_type                  rsp_data,
   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic [kms_pkg::CSR_ADDR_W-1:0]    paddr,
   input  logic [kms_pkg::CSR_DATA_W-1:0]    pwdata,
   output logic [kms_pkg::CSR_DATA_W-1:0]    prdata,
   output logic                              pready
);
   import kms_pkg::*;

   logic              in_valid_ff, in_valid_in;
   req_type           in_data_ff;
   logic              out_valid_ff, out_valid_in;
   rsp_type           out_data_ff;
   logic [DEB_W-1:0]  debounce_ms_ff;

   logic              advance;
   logic              reg_hit;
   scan_result_type   scan_result;
   logic [DRIVE_W-1:0] row_drive;
   logic [CODE_W-1:0] key_event;

   // Configuration register
   assign pready  = 1'b1;
   assign reg_hit = (paddr[CSR_ADDR_W-1:2] == REG_DEBOUNCE_MS);
   assign prdata  = reg_hit ? {{(CSR_DATA_W-DEB_W){1'b0}}, debounce_ms_ff} : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         debounce_ms_ff <= DEBOUNCE_MS_RESET;
      end else if (psel && penable && pwrite && pready && reg_hit) begin
         debounce_ms_ff <= pwdata[DEB_W-1:0];
      end
   end

   // Move a sample into the result register when that register frees up
   assign advance   = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;
   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

   always_comb begin
      in_valid_in  = in_valid_ff;
      out_valid_in = out_valid_ff;
      if (req_ready) begin
         in_valid_in = req_valid;
      end
      if (advance) begin
         out_valid_in = 1'b1;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Hold the sample and the result payload
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_data_ff <= req_data;
      end
      if (advance) begin
         out_data_ff.row_drive <= row_drive;
         out_data_ff.scan_done <= scan_result.done;
         out_data_ff.key_event <= key_event;
      end
   end

   kms_scan #(
      .NUM_ROWS (NUM_ROWS),
      .NUM_COLS (NUM_COLS)
   ) u_kms_scan (
      .clock         (clock),
      .reset         (reset),
      .step          (advance),
      .column_sample (in_data_ff.column_sample),
      .scan_result   (scan_result),
      .row_drive     (row_drive)
   );

   kms_debounce u_kms_debounce (
      .clock       (clock),
      .reset       (reset),
      .step        (advance),
      .scan_result (scan_result),
      .now_ms      (in_data_ff.now_ms),
      .debounce_ms (debounce_ms_ff),
      .key_event   (key_event)
   );

endmodule

@@ hw/rtl/kms_checker.sv @@
// ----------------------------------------------------------------------------
// kms_checker: port-level checks for the keypad scanner
// Watches the result channel and configuration port of the top level.
// ----------------------------------------------------------------------------
module kms_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              rsp_valid,
   input logic                              rsp_ready,
   input kms_pkg::rsp_type                  rsp_data,
   input logic                              pready
);
   import kms_pkg::*;

   // Hold a stalled result
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result changed while stalled");

   // Come out of reset with no result pending
   a_rsp_reset: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result valid right after reset");

   // Report keys only on the transfer that closes a scan
   a_event_done: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.key_event != CODE_NONE) |-> rsp_data.scan_done)
      else $error("key event outside a finished scan");

   // Drive at most one row low
   a_one_row: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $countones(~rsp_data.row_drive) <= 1)
      else $error("more than one row driven");

   // Never stall the configuration port
   a_pready: assert property (@(posedge clock) disable iff (reset)
      pready)
      else $error("pready low");

endmodule

bind keypad_matrix_scan_debounce kms_checker u_kms_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data),
   .pready    (pready)
);
